>>> hdl/sde_pkg.sv
// Shared types, constants and exponent factor table for the softmax derivative engine.
`timescale 1ns / 1ps
package sde_pkg;

  localparam int SAMPLE_W = 16;
  localparam int EXP_W    = 17;
  localparam int GRAD_W   = 16;
  localparam int INDEX_W  = 6;
  localparam int BIT_CNT_W = 5;
  localparam int EXP_BITS = 12;
  localparam int DIV_BITS = 17;
  localparam logic [EXP_W-1:0] EXP_ONE = 17'h10000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [GRAD_W-1:0] GRAD_MAX = 16'd16384;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_EXP_RD,
    ST_EXP_INIT,
    ST_EXP_STEP,
    ST_EXP_WR,
    ST_DIV_RD,
    ST_DIV_MUL,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exp_init;
    logic exp_step;
    logic exp_wr;
    logic div_mul;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic elem_last;
    logic exp_bit_last;
    logic div_bit_last;
    logic out_free;
  } status_t;

  function automatic logic [15:0] exp_factor(input logic [3:0] b);
    logic [15:0] k;
    case (b)
      4'd0:    k = 16'd65280;
      4'd1:    k = 16'd65026;
      4'd2:    k = 16'd64520;
      4'd3:    k = 16'd63520;
      4'd4:    k = 16'd61565;
      4'd5:    k = 16'd57835;
      4'd6:    k = 16'd51039;
      4'd7:    k = 16'd39750;
      4'd8:    k = 16'd24109;
      4'd9:    k = 16'd8869;
      4'd10:   k = 16'd1200;
      4'd11:   k = 16'd22;
      default: k = 16'd0;
    endcase
    return k;
  endfunction

endpackage

>>> hdl/sde_ctrl.sv
// Sequencing state machine for load, exponent, and divide passes.
`timescale 1ns / 1ps
module sde_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  input  sde_pkg::status_t status,
  output logic             in_ready,
  output sde_pkg::cmd_t    cmd
);
  import sde_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:     if (in_valid && in_last) state_next = ST_EXP_RD;
      ST_EXP_RD:   state_next = ST_EXP_INIT;
      ST_EXP_INIT: state_next = ST_EXP_STEP;
      ST_EXP_STEP: if (status.exp_bit_last) state_next = ST_EXP_WR;
      ST_EXP_WR:   state_next = status.elem_last ? ST_DIV_RD : ST_EXP_RD;
      ST_DIV_RD:   state_next = ST_DIV_MUL;
      ST_DIV_MUL:  state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV_STEP;
      ST_DIV_STEP: if (status.div_bit_last) state_next = ST_OUT;
      ST_OUT:      if (status.out_free) state_next = status.elem_last ? ST_LOAD : ST_DIV_RD;
      default:     state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXP_INIT: cmd.exp_init = 1'b1;
      ST_EXP_STEP: cmd.exp_step = 1'b1;
      ST_EXP_WR:   cmd.exp_wr = 1'b1;
      ST_DIV_MUL:  cmd.div_mul = 1'b1;
      ST_DIV_LOAD: cmd.div_load = 1'b1;
      ST_DIV_STEP: cmd.div_step = 1'b1;
      ST_OUT:      cmd.out_load = status.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

>>> hdl/sde_datapath.sv
// Sample and exponent stores, exponent unit, accumulator, divider and output register.
`timescale 1ns / 1ps
module sde_datapath #(
  parameter int MAX_LEN = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sde_pkg::cmd_t                  cmd,
  input  logic [sde_pkg::SAMPLE_W-1:0]   sample,
  output sde_pkg::status_t               status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [sde_pkg::GRAD_W-1:0]     grad,
  output logic [sde_pkg::INDEX_W-1:0]    index,
  output logic                           last_out
);
  import sde_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = EXP_W + AW;
  localparam int PW = EXP_W + SW;
  localparam int WN = 2 * SW + 18;

  logic [SAMPLE_W-1:0] sample_mem [MAX_LEN];
  logic [EXP_W-1:0]    exp_mem [MAX_LEN];

  logic [CW-1:0]        count;
  logic [AW-1:0]        idx;
  logic [SAMPLE_W-1:0]  run_max;
  logic [SW-1:0]        sum;
  logic [SAMPLE_W-1:0]  sample_q;
  logic [EXP_W-1:0]     exp_q;
  logic [EXP_W-1:0]     acc;
  logic [EXP_BITS-1:0]  delta;
  logic [BIT_CNT_W-1:0] bcnt;
  logic [PW-1:0]        prod;
  logic [2*SW-1:0]      den;
  logic [WN-1:0]        rem;
  logic [WN-1:0]        dsh;
  logic [DIV_BITS-1:0]  quo;

  logic [SAMPLE_W:0]    diff;
  logic [33:0]          exp_prod;
  logic                 ge;

  assign diff = {run_max[SAMPLE_W-1], run_max} - {sample_q[SAMPLE_W-1], sample_q};
  assign exp_prod = 34'(acc * exp_factor(bcnt[3:0])) + 34'd32768;
  assign ge = rem >= dsh;

  assign status.full         = count == CW'(MAX_LEN);
  assign status.elem_last    = (CW'(idx) + CW'(1)) == count;
  assign status.exp_bit_last = bcnt == BIT_CNT_W'(EXP_BITS - 1);
  assign status.div_bit_last = bcnt == BIT_CNT_W'(DIV_BITS - 1);
  assign status.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load && !status.full) begin
      sample_mem[count[AW-1:0]] <= sample;
    end
    sample_q <= sample_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_wr) begin
      exp_mem[idx] <= acc;
    end
    exp_q <= exp_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      idx     <= '0;
      run_max <= SAMPLE_MIN;
      sum     <= '0;
    end else begin
      if (cmd.load && !status.full) begin
        count <= count + CW'(1);
        if (count == '0 || $signed(sample) > $signed(run_max)) begin
          run_max <= sample;
        end
      end
      if (cmd.exp_wr) begin
        sum <= sum + SW'(acc);
        idx <= status.elem_last ? '0 : idx + AW'(1);
      end
      if (cmd.out_load) begin
        if (status.elem_last) begin
          count   <= '0;
          idx     <= '0;
          run_max <= SAMPLE_MIN;
          sum     <= '0;
        end else begin
          idx <= idx + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_init) begin
      bcnt <= '0;
      if (diff[SAMPLE_W:EXP_BITS] != '0) begin
        acc   <= '0;
        delta <= '0;
      end else begin
        acc   <= EXP_ONE;
        delta <= diff[EXP_BITS-1:0];
      end
    end
    if (cmd.exp_step) begin
      if (delta[0]) begin
        acc <= exp_prod[32:16];
      end
      delta <= delta >> 1;
      bcnt  <= bcnt + BIT_CNT_W'(1);
    end
    if (cmd.div_mul) begin
      prod <= PW'(exp_q * (sum - SW'(exp_q)));
      den  <= sum * sum;
    end
    if (cmd.div_load) begin
      rem  <= WN'({prod, 17'b0}) + WN'(den);
      dsh  <= WN'({den, 17'b0});
      quo  <= '0;
      bcnt <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo  <= {quo[DIV_BITS-2:0], ge};
      dsh  <= dsh >> 1;
      bcnt <= bcnt + BIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      grad     <= quo[GRAD_W-1:0];
      index    <= INDEX_W'(idx);
      last_out <= status.elem_last;
    end
  end

endmodule

>>> hdl/softmax_derivative_engine.sv
// Top level of the softmax derivative engine: controller plus datapath.
//  channel  signals                              direction
//  in       in_valid in_ready sample last         into block
//  out      out_valid out_ready grad index last_out  out of block
// Loading takes one sample per cycle. A closing sample starts the exp pass,
// which for each element does a store read, init, 12 multiply steps and a write;
// then the divide pass does, for each element, read, multiply, load, 17 steps
// and output, the output waiting until out_ready frees the output register.
// Reset clears count, maximum, sum and output valid; stores need no clearing.
// Input is not taken during the exp and divide passes.
`timescale 1ns / 1ps
module softmax_derivative_engine #(
  parameter int MAX_LEN = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sde_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sde_pkg::GRAD_W-1:0]    grad,
  output logic [sde_pkg::INDEX_W-1:0]   index,
  output logic                          last_out
);
  import sde_pkg::*;

  cmd_t    cmd;
  status_t status;

  sde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (last),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sde_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample    (sample),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .grad      (grad),
    .index     (index),
    .last_out  (last_out)
  );

  a_grad_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> grad <= GRAD_MAX)
    else $error("grad above one quarter");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

>>> test/testbench.sv
// Testbench for the softmax derivative engine: directed table, overflow vector, then random vectors.
`timescale 1ns / 1ps
module testbench;
  import sde_pkg::*;

  localparam int VEC_LEN = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                has_grad;
    logic [GRAD_W-1:0]   grad;
  } stim_row_t;

  typedef struct {
    logic [GRAD_W-1:0]  grad;
    logic [INDEX_W-1:0] index;
    logic               last_out;
  } grad_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [SAMPLE_W-1:0] sample;
  logic last;
  logic out_valid;
  logic out_ready;
  logic [GRAD_W-1:0] grad;
  logic [INDEX_W-1:0] index;
  logic last_out;

  softmax_derivative_engine #(.MAX_LEN(VEC_LEN)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .grad(grad), .index(index), .last_out(last_out)
  );

  logic signed [SAMPLE_W-1:0] vec_samples [VEC_LEN];
  int vec_count;
  logic signed [SAMPLE_W-1:0] vec_max;
  grad_result_t grad_queue [$];
  stim_row_t typed_queue [$];
  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles;

  function automatic logic [EXP_W-1:0] exp_neg(input logic [16:0] delta);
    logic [15:0] k [12];
    logic [47:0] acc;
    k = '{16'd65280, 16'd65026, 16'd64520, 16'd63520, 16'd61565, 16'd57835,
          16'd51039, 16'd39750, 16'd24109, 16'd8869, 16'd1200, 16'd22};
    if (delta >= 17'd4096) return '0;
    acc = 48'd65536;
    for (int b = 0; b < 12; b++) begin
      if (delta[b]) acc = (acc * k[b] + 48'd32768) >> 16;
    end
    return acc[EXP_W-1:0];
  endfunction

  // Accept one sample into the model vector; on close, queue all gradients.
  function automatic void model_sample(input logic [SAMPLE_W-1:0] x, input logic cl);
    logic [EXP_W-1:0] e [VEC_LEN];
    logic [63:0] s, den, num, g;
    grad_result_t r;
    if (vec_count < VEC_LEN) begin
      if (vec_count == 0 || $signed(x) > vec_max) vec_max = x;
      vec_samples[vec_count] = x;
      vec_count++;
    end
    if (!cl) return;
    s = 0;
    for (int i = 0; i < vec_count; i++) begin
      e[i] = exp_neg(17'(int'(vec_max) - int'(vec_samples[i])));
      s += 64'(e[i]);
    end
    den = s * s;
    for (int i = 0; i < vec_count; i++) begin
      num = 64'(e[i]) * (s - 64'(e[i])) * 64'd65536;
      g = (num + den / 2) / den;
      r.grad = g[GRAD_W-1:0];
      r.index = i[INDEX_W-1:0];
      r.last_out = (i + 1 == vec_count);
      grad_queue.push_back(r);
    end
    vec_count = 0;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic cl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= x;
    last <= cl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold until every queued result has been checked.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (grad_queue.size() > 0);
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) model_sample(sample, last);
  end

  always @(posedge clk) begin
    grad_result_t exp_r;
    stim_row_t typed_r;
    if (!rst && out_valid && out_ready) begin
      if (grad_queue.size() == 0) begin
        $error("unexpected result grad=%0d index=%0d", grad, index);
        fail_count++;
      end else begin
        exp_r = grad_queue.pop_front();
        if (typed_queue.size() > 0) begin
          typed_r = typed_queue.pop_front();
          if (typed_r.has_grad && grad !== typed_r.grad) begin
            $error("grad expected %0d actual %0d", typed_r.grad, grad);
            fail_count++;
          end
        end
        if (grad !== exp_r.grad) begin
          $error("grad expected %0d actual %0d", exp_r.grad, grad);
          fail_count++;
        end
        if (index !== exp_r.index) begin
          $error("index expected %0d actual %0d", exp_r.index, index);
          fail_count++;
        end
        if (last_out !== exp_r.last_out) begin
          $error("last_out expected %0d actual %0d", exp_r.last_out, last_out);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Directed rows; expected grad typed only for trivially known cases.
  stim_row_t dir_rows [15] = '{
    '{16'sh0100, 1'b1, 1'b1, 16'd0},
    '{16'sh7FFF, 1'b0, 1'b0, 16'd0}, '{16'sh8000, 1'b1, 1'b1, 16'd0},
    '{16'sh0000, 1'b0, 1'b1, 16'd16384}, '{16'sh0000, 1'b1, 1'b1, 16'd16384},
    '{16'sh8000, 1'b0, 1'b1, 16'd16384}, '{16'sh8000, 1'b1, 1'b1, 16'd16384},
    '{16'sh0FFF, 1'b0, 1'b0, 16'd0}, '{16'sh0000, 1'b0, 1'b0, 16'd0},
    '{16'shFFFF, 1'b0, 1'b0, 16'd0}, '{16'sh0555, 1'b0, 1'b0, 16'd0},
    '{16'shAAAA, 1'b1, 1'b0, 16'd0},
    '{16'sh0001, 1'b0, 1'b0, 16'd0}, '{16'sh0002, 1'b0, 1'b0, 16'd0},
    '{16'sh0004, 1'b1, 1'b0, 16'd0}
  };

  task automatic run_vector(input int len, input bit spread);
    logic [SAMPLE_W-1:0] base, x;
    base = SAMPLE_W'($urandom);
    for (int i = 0; i < len; i++) begin
      if (spread || $urandom_range(9) == 0) x = SAMPLE_W'($urandom);
      else x = SAMPLE_W'(base + $urandom_range(2047) - 1024);
      send_sample(x, i == len - 1);
    end
  endtask

  initial begin
    rst = 1; in_valid = 0; sample = '0; last = 0; out_ready = 0;
    send_idle_pct = 32; recv_idle_pct = 59;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (dir_rows[r]) begin
      typed_queue.push_back(dir_rows[r]);
      send_sample(dir_rows[r].sample, dir_rows[r].last);
      if (dir_rows[r].last) drain_results();
    end
    // Overflow: 70 samples, the dropped last one still closes.
    for (int i = 0; i < 70; i++) send_sample(SAMPLE_W'($urandom), i == 69);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 59 : 0;
      recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 32 : 0;
      repeat (6) begin
        run_vector(int'($urandom_range(8) == 0 ? $urandom_range(33, 64)
                                               : $urandom_range(1, 6)),
                   $urandom_range(3) == 0);
      end
    end
    drain_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

>>> filelist.f
hdl/sde_pkg.sv
hdl/sde_ctrl.sv
hdl/sde_datapath.sv
hdl/softmax_derivative_engine.sv
test/testbench.sv
